### rtl/core/sis_pkg.sv
package sis_pkg;

  localparam int MAX_ITEMS_DEF = 32;
  localparam int KEY_W         = 8;
  localparam int TAG_W         = 16;
  localparam int DATA_W        = 24;  // key + tag, already whole bytes

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the new entry in key order
    logic shl;  // shift the whole row one cell toward the head
  } cell_ctl_t;

endpackage

### rtl/core/sis_cell.sv
module sis_cell
  import sis_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  logic      occ,       // this cell holds an entry
  input  logic      occ_prev,  // neighbor toward the head holds an entry
  input  logic      gt_prev,   // neighbor toward the head moves right on insert
  input  entry_t    prev_entry,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      gt
);

  entry_t entry_next;

  // strictly greater: equal keys stay ahead of the new one (stable)
  assign gt = occ && (entry.key > new_entry.key);

  always_comb begin
    entry_next = entry;
    if (ctl.shl) begin
      entry_next = next_entry;
    end else if (ctl.ins) begin
      if (gt_prev) begin
        entry_next = prev_entry;
      end else if (gt || (!occ && occ_prev)) begin
        entry_next = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### rtl/core/stable_insertion_sorter.sv
// Channel   Dir  Beat contents (tdata low bit first)            Sideband
// s_axis    in   sort_key[7:0], payload_tag[23:8]                tlast = is_last
// m_axis    out  out_key[7:0], out_tag[23:8]                     tlast = end_of_run,
//                                                                tuser = overflowed
//
// Loading takes one input beat per cycle; a row of MAX_ITEMS cells opens a gap
// at the key's place in the same cycle the beat is taken.
// After a tlast beat the row drains from its head, one result per cycle while
// m_tready is high; s_tready stays low until every entry held has left the row.
// Beats beyond MAX_ITEMS are dropped; tuser marks every result of that run.
// rst is synchronous, active high; it empties the row and the output register.
// The output register lets the next run start loading while the final result waits.
module stable_insertion_sorter
  import sis_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // sort_key[7:0], payload_tag[23:8]
  input  logic              s_tlast,   // is_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // out_key[7:0], out_tag[23:8]
  output logic              m_tlast,   // end_of_run
  output logic              m_tuser    // overflowed
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             dropped, dropped_next;
  logic             out_v, out_v_next;
  entry_t           out_entry;
  logic             out_end, out_ovf;

  logic             s_beat, full, ld;
  entry_t           new_entry;
  cell_ctl_t        ctl;

  entry_t           cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] occ;
  logic [MAX_ITEMS-1:0] gt;

  assign s_tready  = (state == ST_LOAD);
  assign s_beat    = s_tvalid && s_tready;
  assign full      = (count == CNT_W'(MAX_ITEMS));
  assign new_entry = '{key: s_tdata[KEY_W-1:0], tag: s_tdata[KEY_W +: TAG_W]};

  // take the head cell into the output register when it is free
  assign ld = (state == ST_DRAIN) && (!out_v || m_tready);

  assign ctl.ins = s_beat && !full;
  assign ctl.shl = ld;

  // occupancy is a thermometer of the count
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      occ[i] = count > CNT_W'(i);
    end
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_row
    entry_t pe, ne;
    logic   op, gp;
    if (g == 0) begin : g_head
      assign pe = new_entry;
      assign op = 1'b1;
      assign gp = 1'b0;
    end else begin : g_mid
      assign pe = cells[g-1];
      assign op = occ[g-1];
      assign gp = gt[g-1];
    end
    if (g == MAX_ITEMS - 1) begin : g_tail
      assign ne = cells[g];  // vacated slot; count marks it empty
    end else begin : g_body
      assign ne = cells[g+1];
    end

    sis_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .occ        (occ[g]),
      .occ_prev   (op),
      .gt_prev    (gp),
      .prev_entry (pe),
      .next_entry (ne),
      .entry      (cells[g]),
      .gt         (gt[g])
    );
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    out_v_next   = out_v;
    if (m_tready) begin
      out_v_next = 1'b0;
    end
    case (state)
      ST_LOAD: begin
        if (s_beat) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
          if (s_tlast) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (ld) begin
          out_v_next = 1'b1;
          count_next = count - 1'b1;
          if (count == CNT_W'(1)) begin
            state_next   = ST_LOAD;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      out_v   <= out_v_next;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (ld) begin
      out_entry <= cells[0];
      out_end   <= (count == CNT_W'(1));
      out_ovf   <= dropped;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {out_entry.tag, out_entry.key};
  assign m_tlast  = out_end;
  assign m_tuser  = out_ovf;

endmodule

### rtl/core/sis_checker.sv
module sis_checker
  import sis_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              s_tlast,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tlast,
  input logic              m_tuser
);

  // a last beat always starts a drain of at least one entry
  a_drain_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input not stalled after last beat");

  // the input only stalls right after a last beat was taken
  a_stall_only_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid && s_tlast))
    else $error("input stalled without a last beat");

  // no new result appears while the block stays loading a run
  a_no_result_while_loading: assert property (@(posedge clk) disable iff (rst)
    s_tready && !m_tvalid |=> !m_tvalid || s_tready == 1'b0 || $past(s_tready) == 1'b0)
    else $error("result appeared during loading");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind stable_insertion_sorter sis_checker u_sis_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
